// ----- hw/rtl/nnsa_pkg.sv -----
// ----------------------------------------------------------------------------
// nnsa_pkg
// Shared types, constants and helpers for the nearest-neighbor scale address
// generator: field widths, register indexes, the front-to-back item record.
// ----------------------------------------------------------------------------
package nnsa_pkg;

   localparam int unsigned MAX_DIM         = 4096;
   localparam int unsigned BYTES_PER_PIXEL = 4;
   localparam int unsigned CNT_LIMIT       = 4096;
   localparam int unsigned DIM_LIMIT       = (MAX_DIM < CNT_LIMIT) ? MAX_DIM : CNT_LIMIT;

   localparam int unsigned CNT_W   = 12;
   localparam int unsigned DIM_W   = 13;
   localparam int unsigned PITCH_W = 16;
   localparam int unsigned OFS_W   = 28;
   localparam int unsigned PROD_W  = CNT_W + DIM_W;
   localparam int unsigned REM_W   = DIM_W + 1;
   localparam int unsigned STEP_W  = $clog2(PROD_W);

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);

   localparam int unsigned ADDR_W = 5;
   localparam int unsigned DATA_W = 32;

   typedef logic [2:0] reg_index_type;
   localparam reg_index_type REG_SRC_COLS      = 3'd0;
   localparam reg_index_type REG_SRC_ROWS      = 3'd1;
   localparam reg_index_type REG_SRC_ROW_BYTES = 3'd2;
   localparam reg_index_type REG_DST_COLS      = 3'd3;
   localparam reg_index_type REG_DST_ROWS      = 3'd4;
   localparam reg_index_type REG_DST_ROW_BYTES = 3'd5;

   // Effective geometry as seen by the datapath (dimensions already clamped)
   typedef struct packed {
      logic [DIM_W-1:0]   src_cols;
      logic [DIM_W-1:0]   src_rows;
      logic [PITCH_W-1:0] src_row_bytes;
      logic [DIM_W-1:0]   dst_cols;
      logic [DIM_W-1:0]   dst_rows;
      logic [PITCH_W-1:0] dst_row_bytes;
   } cfg_type;

   // One classified item on its way from the front to the back
   typedef struct packed {
      logic [CNT_W-1:0] x;
      logic [CNT_W-1:0] y;
      logic             row_end;
      logic             frame_end;
   } task_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Zero acts as one, anything past the counter range acts as the limit
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(DIM_LIMIT)) begin
         r = DIM_W'(DIM_LIMIT);
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/nearest_neighbor_scale_addresses.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_addresses
// Framebuffer address generator for nearest-neighbor scaling: one item per
// destination pixel in raster order, giving source and destination
// coordinates, byte offsets and row/frame end flags.
//
//   channel   ports            direction   payload
//   request   req_*            in          restart
//   response  rsp_*            out         coordinates, offsets, end flags
//   config    psel..pready     in/out      six geometry registers
//
// For each item the address unit runs a 25-step restoring divider once for
// the column and once for the row, plus load, offset multiply and output
// steps.
// The front accepts one item per cycle until the two-entry queue fills.
// Reset is synchronous; no clearing pass.
// A stalled response holds the address unit in its final step.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_addresses (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [nnsa_pkg::CNT_W-1:0]        rsp_out_x,
   output logic [nnsa_pkg::CNT_W-1:0]        rsp_out_y,
   output logic [nnsa_pkg::CNT_W-1:0]        rsp_from_x,
   output logic [nnsa_pkg::CNT_W-1:0]        rsp_from_y,
   output logic [nnsa_pkg::OFS_W-1:0]        rsp_from_offset,
   output logic [nnsa_pkg::OFS_W-1:0]        rsp_to_offset,
   output logic                              rsp_row_end,
   output logic                              rsp_frame_end,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [nnsa_pkg::ADDR_W-1:0]       paddr,
   input  logic [nnsa_pkg::DATA_W-1:0]       pwdata,
   output logic [nnsa_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);

   localparam int unsigned DIM_W   = nnsa_pkg::DIM_W;
   localparam int unsigned PITCH_W = nnsa_pkg::PITCH_W;
   localparam int unsigned DATA_W  = nnsa_pkg::DATA_W;

   logic [DIM_W-1:0]   src_cols_ff, src_rows_ff, dst_cols_ff, dst_rows_ff;
   logic [PITCH_W-1:0] src_row_bytes_ff, dst_row_bytes_ff;

   nnsa_pkg::reg_index_type    reg_index;
   logic                       csr_write;
   nnsa_pkg::cfg_type          cfg;
   nnsa_pkg::queue_status_type q_status;
   nnsa_pkg::task_type         push_item, head;
   logic                       push, pop;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_cols_ff      <= DIM_W'(1920);
         src_rows_ff      <= DIM_W'(1080);
         src_row_bytes_ff <= PITCH_W'(7680);
         dst_cols_ff      <= DIM_W'(1920);
         dst_rows_ff      <= DIM_W'(1080);
         dst_row_bytes_ff <= PITCH_W'(7680);
      end else if (csr_write) begin
         unique case (reg_index)
            nnsa_pkg::REG_SRC_COLS:      src_cols_ff      <= pwdata[DIM_W-1:0];
            nnsa_pkg::REG_SRC_ROWS:      src_rows_ff      <= pwdata[DIM_W-1:0];
            nnsa_pkg::REG_SRC_ROW_BYTES: src_row_bytes_ff <= pwdata[PITCH_W-1:0];
            nnsa_pkg::REG_DST_COLS:      dst_cols_ff      <= pwdata[DIM_W-1:0];
            nnsa_pkg::REG_DST_ROWS:      dst_rows_ff      <= pwdata[DIM_W-1:0];
            nnsa_pkg::REG_DST_ROW_BYTES: dst_row_bytes_ff <= pwdata[PITCH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         nnsa_pkg::REG_SRC_COLS:      prdata = DATA_W'(src_cols_ff);
         nnsa_pkg::REG_SRC_ROWS:      prdata = DATA_W'(src_rows_ff);
         nnsa_pkg::REG_SRC_ROW_BYTES: prdata = DATA_W'(src_row_bytes_ff);
         nnsa_pkg::REG_DST_COLS:      prdata = DATA_W'(dst_cols_ff);
         nnsa_pkg::REG_DST_ROWS:      prdata = DATA_W'(dst_rows_ff);
         nnsa_pkg::REG_DST_ROW_BYTES: prdata = DATA_W'(dst_row_bytes_ff);
         default:                     prdata = '0;
      endcase
   end

   always_comb begin
      cfg.src_cols      = nnsa_pkg::eff_dim(src_cols_ff);
      cfg.src_rows      = nnsa_pkg::eff_dim(src_rows_ff);
      cfg.src_row_bytes = src_row_bytes_ff;
      cfg.dst_cols      = nnsa_pkg::eff_dim(dst_cols_ff);
      cfg.dst_rows      = nnsa_pkg::eff_dim(dst_rows_ff);
      cfg.dst_row_bytes = dst_row_bytes_ff;
   end

   nnsa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .cfg         (cfg),
      .q_status    (q_status),
      .push        (push),
      .push_item   (push_item)
   );

   nnsa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   nnsa_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .q_status        (q_status),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_from_x      (rsp_from_x),
      .rsp_from_y      (rsp_from_y),
      .rsp_from_offset (rsp_from_offset),
      .rsp_to_offset   (rsp_to_offset),
      .rsp_row_end     (rsp_row_end),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule

// ----- hw/rtl/nnsa_front.sv -----
// ----------------------------------------------------------------------------
// nnsa_front
// Raster walker: accepts items, applies restart, flags row and frame ends,
// advances the destination counters and pushes the item into the queue.
// ----------------------------------------------------------------------------
module nnsa_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_restart,
   input  nnsa_pkg::cfg_type                     cfg,
   input  nnsa_pkg::queue_status_type            q_status,
   output logic                                  push,
   output nnsa_pkg::task_type                    push_item
);

   logic [nnsa_pkg::CNT_W-1:0] col_ff, col_in;
   logic [nnsa_pkg::CNT_W-1:0] row_ff, row_in;
   logic [nnsa_pkg::CNT_W-1:0] x, y;
   logic                       row_end, frame_end;

   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      x = req_restart ? '0 : col_ff;
      y = req_restart ? '0 : row_ff;
      row_end   = {1'b0, x} >= (cfg.dst_cols - nnsa_pkg::DIM_W'(1));
      frame_end = row_end && ({1'b0, y} >= (cfg.dst_rows - nnsa_pkg::DIM_W'(1)));

      push_item.x         = x;
      push_item.y         = y;
      push_item.row_end   = row_end;
      push_item.frame_end = frame_end;

      priority if (frame_end) begin
         col_in = '0;
         row_in = '0;
      end else if (row_end) begin
         col_in = '0;
         row_in = y + nnsa_pkg::CNT_W'(1);
      end else begin
         col_in = x + nnsa_pkg::CNT_W'(1);
         row_in = y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (push) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ----- hw/rtl/nnsa_queue.sv -----
// ----------------------------------------------------------------------------
// nnsa_queue
// Short item queue that decouples the raster walker from the address unit.
// ----------------------------------------------------------------------------
module nnsa_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  nnsa_pkg::task_type         push_item,
   input  logic                       pop,
   output nnsa_pkg::task_type         head,
   output nnsa_pkg::queue_status_type q_status
);

   nnsa_pkg::task_type         entry_ff [nnsa_pkg::QUEUE_DEPTH];
   logic [nnsa_pkg::PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [nnsa_pkg::PTR_W:0]   count_ff, count_in;

   assign q_status.full  = count_ff == (nnsa_pkg::PTR_W + 1)'(nnsa_pkg::QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;
   assign head           = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + (nnsa_pkg::PTR_W + 1)'(1);
         2'b01:   count_in = count_ff - (nnsa_pkg::PTR_W + 1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + nnsa_pkg::PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + nnsa_pkg::PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hw/rtl/nnsa_back.sv -----
// ----------------------------------------------------------------------------
// nnsa_back
// Address unit: maps destination coordinates to source coordinates with a
// shared restoring divider, forms both byte offsets and holds the result.
// ----------------------------------------------------------------------------
module nnsa_back (
   input  logic                              clock,
   input  logic                              reset,
   input  nnsa_pkg::cfg_type                 cfg,
   input  nnsa_pkg::queue_status_type        q_status,
   input  nnsa_pkg::task_type                head,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [nnsa_pkg::CNT_W-1:0]        rsp_out_x,
   output logic [nnsa_pkg::CNT_W-1:0]        rsp_out_y,
   output logic [nnsa_pkg::CNT_W-1:0]        rsp_from_x,
   output logic [nnsa_pkg::CNT_W-1:0]        rsp_from_y,
   output logic [nnsa_pkg::OFS_W-1:0]        rsp_from_offset,
   output logic [nnsa_pkg::OFS_W-1:0]        rsp_to_offset,
   output logic                              rsp_row_end,
   output logic                              rsp_frame_end
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_OFS  = 5'b01000,
      ST_SUM  = 5'b10000
   } state_type;

   localparam int unsigned CNT_W  = nnsa_pkg::CNT_W;
   localparam int unsigned DIM_W  = nnsa_pkg::DIM_W;
   localparam int unsigned PROD_W = nnsa_pkg::PROD_W;
   localparam int unsigned REM_W  = nnsa_pkg::REM_W;
   localparam int unsigned STEP_W = nnsa_pkg::STEP_W;
   localparam int unsigned OFS_W  = nnsa_pkg::OFS_W;

   state_type          state_ff, state_in;
   nnsa_pkg::task_type item_ff;
   logic               sel_y_ff, sel_y_in;
   logic [PROD_W-1:0]  dvd_ff, dvd_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]   fx_ff, fy_ff;
   logic [OFS_W-1:0]   from_mul_ff, to_mul_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               load_rsp;

   logic [CNT_W-1:0]   pos;
   logic [DIM_W-1:0]   src_n, dst_n, src_m1;
   logic [REM_W-1:0]   rem_shift;
   logic               ge;
   logic [PROD_W-1:0]  quot;
   logic [CNT_W-1:0]   q_sat;
   logic               last_step;

   // Shared divider operands: column pass first, then row pass
   always_comb begin
      pos       = sel_y_ff ? item_ff.y : item_ff.x;
      src_n     = sel_y_ff ? cfg.src_rows : cfg.src_cols;
      dst_n     = sel_y_ff ? cfg.dst_rows : cfg.dst_cols;
      src_m1    = src_n - DIM_W'(1);
      rem_shift = {rem_ff[REM_W-2:0], dvd_ff[PROD_W-1]};
      ge        = rem_shift >= {1'b0, dst_n};
      quot      = {dvd_ff[PROD_W-2:0], ge};
      // Saturate to the last source column or row
      q_sat     = (quot > PROD_W'(src_m1)) ? src_m1[CNT_W-1:0] : quot[CNT_W-1:0];
      last_step = step_ff == STEP_W'(PROD_W - 1);
      load_rsp  = (state_ff == ST_SUM) && (!rsp_valid_ff || rsp_ready);
      pop       = (state_ff == ST_IDLE) && !q_status.empty;
   end

   always_comb begin
      state_in = state_ff;
      sel_y_in = sel_y_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               sel_y_in = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            dvd_in   = {{DIM_W{1'b0}}, pos} * {{CNT_W{1'b0}}, src_n};
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            dvd_in  = quot;
            rem_in  = ge ? (rem_shift - {1'b0, dst_n}) : rem_shift;
            step_in = step_ff + STEP_W'(1);
            if (last_step) begin
               sel_y_in = 1'b1;
               state_in = sel_y_ff ? ST_OFS : ST_MUL;
            end
         end
         ST_OFS: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_y_ff <= sel_y_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      if (pop) begin
         item_ff <= head;
      end
      if ((state_ff == ST_DIV) && last_step) begin
         if (sel_y_ff) begin
            fy_ff <= q_sat;
         end else begin
            fx_ff <= q_sat;
         end
      end
      if (state_ff == ST_OFS) begin
         from_mul_ff <= {{(OFS_W - CNT_W){1'b0}}, fy_ff}
                      * {{(OFS_W - nnsa_pkg::PITCH_W){1'b0}}, cfg.src_row_bytes};
         to_mul_ff   <= {{(OFS_W - CNT_W){1'b0}}, item_ff.y}
                      * {{(OFS_W - nnsa_pkg::PITCH_W){1'b0}}, cfg.dst_row_bytes};
      end
      if (load_rsp) begin
         rsp_out_x       <= item_ff.x;
         rsp_out_y       <= item_ff.y;
         rsp_from_x      <= fx_ff;
         rsp_from_y      <= fy_ff;
         rsp_from_offset <= from_mul_ff
                          + OFS_W'(fx_ff) * OFS_W'(nnsa_pkg::BYTES_PER_PIXEL);
         rsp_to_offset   <= to_mul_ff
                          + OFS_W'(item_ff.x) * OFS_W'(nnsa_pkg::BYTES_PER_PIXEL);
         rsp_row_end     <= item_ff.row_end;
         rsp_frame_end   <= item_ff.frame_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/nnsa_checker.sv -----
// ----------------------------------------------------------------------------
// nnsa_checker
// Port-level checks for the scale address generator, bound to the top level.
// ----------------------------------------------------------------------------
module nnsa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [nnsa_pkg::CNT_W-1:0]     rsp_out_x,
   input logic [nnsa_pkg::CNT_W-1:0]     rsp_out_y,
   input logic [nnsa_pkg::CNT_W-1:0]     rsp_from_x,
   input logic [nnsa_pkg::CNT_W-1:0]     rsp_from_y,
   input logic [nnsa_pkg::OFS_W-1:0]     rsp_from_offset,
   input logic [nnsa_pkg::OFS_W-1:0]     rsp_to_offset,
   input logic                           rsp_row_end,
   input logic                           rsp_frame_end
);

   // Response register is empty right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled item stays valid and holds its coordinates and offsets
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
         && $stable(rsp_from_offset) && $stable(rsp_to_offset))
      else $error("stalled response changed");

   // A frame always ends at a row end
   a_frame_in_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");

   // The origin maps to the source origin at offset zero
   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_x == '0 && rsp_out_y == '0 |->
         rsp_from_x == '0 && rsp_from_y == '0 && rsp_from_offset == '0
         && rsp_to_offset == '0)
      else $error("origin pixel does not map to origin");

endmodule

bind nearest_neighbor_scale_addresses nnsa_checker u_nnsa_checker (.*);
